// ----- hdl/vphd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vphd_pkg
// shared types and constants of the valve pulse and hold driver
// ----------------------------------------------------------------------------
package vphd_pkg;

    localparam int VALVE_COUNT_DEFAULT = 2;
    localparam int VALVE_INDEX_W       = 3;
    localparam int MASK_W              = 8;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 16;
    localparam int PULSE_W             = 10;
    localparam int PHASE_W             = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_PULSE_MS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_PERIOD_TICKS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_ON_TICKS     = 2'd3;

    // configuration reset values
    localparam logic                  CONTROL_MODE_RESET = 1'b0;
    localparam logic [CFG_DATA_W-1:0] OPEN_PULSE_RESET   = 16'd300;
    localparam logic [CFG_DATA_W-1:0] HOLD_PERIOD_RESET  = 16'd3;
    localparam logic [CFG_DATA_W-1:0] HOLD_ON_RESET      = 16'd2;

    // pulse length in ticks: ceil(ms / 100) via reciprocal multiply
    localparam logic [CFG_DATA_W-1:0] PULSE_DEFAULT_MS = 16'd300;
    localparam logic [16:0]           PULSE_ROUND_MS   = 17'd99;
    localparam logic [16:0]           PULSE_RECIP      = 17'd83887;  // ceil(2^23 / 100)
    localparam int                    PULSE_SHIFT      = 23;

    localparam logic CTRL_PULSE_HOLD = 1'b0;
    localparam logic CTRL_LEVEL      = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_OPEN    = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_INVALID = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLOSED  = 2'd0,
        ST_OPENING = 2'd1,
        ST_OPEN    = 2'd2
    } valve_mode_t;

    typedef struct packed {
        op_t                      operation;
        logic [VALVE_INDEX_W-1:0] valve_index;
    } request_t;

    typedef struct packed {
        logic              error;
        valve_mode_t       valve_status;
        logic [MASK_W-1:0] coil_drive_mask;
    } result_t;

endpackage

// ----- hdl/valve_pulse_hold_driver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_pulse_hold_driver_unit
// peak and hold coil driver for a small set of valves, one event per request
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid / in_ready  vphd_pkg::request_t (operation, valve_index)
//  out       output     out_valid/out_ready  vphd_pkg::result_t (error, status, coil mask)
//  cfg       input      cfg_we               cfg_index, cfg_data (write only)
//
//  one request per clock cycle while the result register is not stalled;
//  a request passes the input register and then the result register
//  reset (rst_n low) closes every valve, releases every coil and restores
//  the register defaults; no clearing pass is needed
//  a stalled result register holds the request in the input register, and
//  the input side stops taking requests until the result side drains
// ----------------------------------------------------------------------------
module valve_pulse_hold_driver_unit #(
    parameter int VALVE_COUNT = vphd_pkg::VALVE_COUNT_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  vphd_pkg::request_t                   in_data,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output vphd_pkg::result_t                    out_data,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [vphd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vphd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    logic                              control_mode_reg;
    logic [vphd_pkg::CFG_DATA_W-1:0]   open_pulse_ms_reg;
    logic [vphd_pkg::CFG_DATA_W-1:0]   hold_period_reg;
    logic [vphd_pkg::CFG_DATA_W-1:0]   hold_on_reg;

    // input register stage
    logic                              in_valid_reg;
    vphd_pkg::request_t                in_data_reg;

    // result register stage
    logic                              out_valid_reg;
    vphd_pkg::result_t                 out_data_reg;
    vphd_pkg::result_t                 out_data_next;

    // per-valve state
    logic [vphd_pkg::PULSE_W-1:0]      pulse_left_reg   [VALVE_COUNT];
    logic [vphd_pkg::PULSE_W-1:0]      pulse_left_next  [VALVE_COUNT];
    logic [vphd_pkg::PHASE_W-1:0]      pwm_phase_reg    [VALVE_COUNT];
    logic [vphd_pkg::PHASE_W-1:0]      pwm_phase_next   [VALVE_COUNT];
    vphd_pkg::valve_mode_t             valve_mode_reg   [VALVE_COUNT];
    vphd_pkg::valve_mode_t             valve_mode_next  [VALVE_COUNT];
    vphd_pkg::valve_mode_t             target_mode_reg  [VALVE_COUNT];
    vphd_pkg::valve_mode_t             target_mode_next [VALVE_COUNT];
    logic [VALVE_COUNT-1:0]            hold_enabled_reg;
    logic [VALVE_COUNT-1:0]            hold_enabled_next;
    logic [VALVE_COUNT-1:0]            coil_on_reg;
    logic [VALVE_COUNT-1:0]            coil_on_next;

    // pulse length derived from the live register
    logic [vphd_pkg::CFG_DATA_W-1:0]   pulse_len_ms;
    logic [16:0]                       pulse_len_round;
    logic [33:0]                       pulse_prod;
    logic [vphd_pkg::PULSE_W-1:0]      pulse_ticks;

    // hold on time clamped to the period
    logic [vphd_pkg::CFG_DATA_W-1:0]   hold_on_clamped;

    logic                              advance;
    logic                              index_ok;

    // pwm output for one valve at a given phase
    function automatic logic hold_coil(
        input logic                            enabled,
        input logic [vphd_pkg::PHASE_W-1:0]    phase,
        input logic [vphd_pkg::CFG_DATA_W-1:0] period,
        input logic [vphd_pkg::CFG_DATA_W-1:0] on_time
    );
        logic result;
        if (!enabled || (period == '0))
        begin
            result = 1'b0;
        end
        else
        begin
            result = (on_time >= period) || (phase < on_time);
        end
        return result;
    endfunction

    // a request leaves the input register when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // zero length pulse setting means the default length
    assign pulse_len_ms    = (open_pulse_ms_reg != '0) ? open_pulse_ms_reg
                                                       : vphd_pkg::PULSE_DEFAULT_MS;
    assign pulse_len_round = {1'b0, pulse_len_ms} + vphd_pkg::PULSE_ROUND_MS;
    assign pulse_prod      = 34'(pulse_len_round) * 34'(vphd_pkg::PULSE_RECIP);
    assign pulse_ticks     = pulse_prod[vphd_pkg::PULSE_SHIFT +: vphd_pkg::PULSE_W];

    assign hold_on_clamped = (hold_on_reg > hold_period_reg) ? hold_period_reg : hold_on_reg;

    assign index_ok = ({1'b0, in_data_reg.valve_index} < 4'(VALVE_COUNT));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg  <= vphd_pkg::CONTROL_MODE_RESET;
            open_pulse_ms_reg <= vphd_pkg::OPEN_PULSE_RESET;
            hold_period_reg   <= vphd_pkg::HOLD_PERIOD_RESET;
            hold_on_reg       <= vphd_pkg::HOLD_ON_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vphd_pkg::CFG_CONTROL_MODE:      control_mode_reg  <= cfg_data[0];
                vphd_pkg::CFG_OPEN_PULSE_MS:     open_pulse_ms_reg <= cfg_data;
                vphd_pkg::CFG_HOLD_PERIOD_TICKS: hold_period_reg   <= cfg_data;
                vphd_pkg::CFG_HOLD_ON_TICKS:     hold_on_reg       <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // next valve state and result for the request in the input register
    always_comb
    begin
        logic [vphd_pkg::PHASE_W-1:0] phase_step;
        logic [vphd_pkg::PULSE_W-1:0] pulse_dec;
        logic                         hit;

        out_data_next = '0;
        for (int v = 0; v < VALVE_COUNT; v++)
        begin
            phase_step           = '0;
            pulse_dec            = '0;
            pulse_left_next[v]   = pulse_left_reg[v];
            pwm_phase_next[v]    = pwm_phase_reg[v];
            valve_mode_next[v]   = valve_mode_reg[v];
            target_mode_next[v]  = target_mode_reg[v];
            hold_enabled_next[v] = hold_enabled_reg[v];
            coil_on_next[v]      = coil_on_reg[v];

            hit = index_ok && (in_data_reg.valve_index == vphd_pkg::VALVE_INDEX_W'(v));

            case (in_data_reg.operation)
                vphd_pkg::OP_TICK:
                begin
                    // every valve advances on a tick, addressed or not
                    if (pulse_left_reg[v] == '0)
                    begin
                        if (hold_enabled_reg[v] && (valve_mode_reg[v] == vphd_pkg::ST_OPEN))
                        begin
                            phase_step = pwm_phase_reg[v];
                            if (hold_period_reg != '0)
                            begin
                                phase_step = pwm_phase_reg[v] + 1'b1;
                                if (phase_step >= hold_period_reg)
                                begin
                                    phase_step = '0;
                                end
                            end
                            pwm_phase_next[v] = phase_step;
                            coil_on_next[v]   = hold_coil(1'b1, phase_step,
                                                          hold_period_reg, hold_on_clamped);
                        end
                    end
                    else
                    begin
                        pulse_dec          = pulse_left_reg[v] - 1'b1;
                        pulse_left_next[v] = pulse_dec;
                        if (pulse_dec == '0)
                        begin
                            // opening pulse done, settle into the target mode
                            valve_mode_next[v] = target_mode_reg[v];
                            if ((target_mode_reg[v] == vphd_pkg::ST_OPEN)
                                && hold_enabled_reg[v])
                            begin
                                pwm_phase_next[v] = '0;
                                coil_on_next[v]   = hold_coil(1'b1, '0,
                                                              hold_period_reg, hold_on_clamped);
                            end
                            else
                            begin
                                coil_on_next[v] = 1'b0;
                            end
                        end
                    end
                end
                vphd_pkg::OP_OPEN:
                begin
                    if (hit)
                    begin
                        pwm_phase_next[v]   = '0;
                        coil_on_next[v]     = 1'b1;
                        target_mode_next[v] = vphd_pkg::ST_OPEN;
                        if (control_mode_reg == vphd_pkg::CTRL_PULSE_HOLD)
                        begin
                            valve_mode_next[v]   = vphd_pkg::ST_OPENING;
                            pulse_left_next[v]   = pulse_ticks;
                            hold_enabled_next[v] = 1'b1;
                        end
                        else
                        begin
                            valve_mode_next[v]   = vphd_pkg::ST_OPEN;
                            pulse_left_next[v]   = '0;
                            hold_enabled_next[v] = 1'b0;
                        end
                    end
                end
                vphd_pkg::OP_CLOSE:
                begin
                    if (hit)
                    begin
                        hold_enabled_next[v] = 1'b0;
                        pwm_phase_next[v]    = '0;
                        coil_on_next[v]      = 1'b0;
                        pulse_left_next[v]   = '0;
                        target_mode_next[v]  = vphd_pkg::ST_CLOSED;
                        valve_mode_next[v]   = vphd_pkg::ST_CLOSED;
                    end
                end
                default:
                begin
                    // invalid operation leaves every valve as it is
                end
            endcase

            if (hit)
            begin
                out_data_next.valve_status = valve_mode_next[v];
            end
            out_data_next.coil_drive_mask[v] = coil_on_next[v];
        end

        out_data_next.error = !index_ok || (in_data_reg.operation == vphd_pkg::OP_INVALID);
    end

    // valve state, updated as the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VALVE_COUNT; v++)
            begin
                pulse_left_reg[v]  <= '0;
                pwm_phase_reg[v]   <= '0;
                valve_mode_reg[v]  <= vphd_pkg::ST_CLOSED;
                target_mode_reg[v] <= vphd_pkg::ST_CLOSED;
            end
            hold_enabled_reg <= '0;
            coil_on_reg      <= '0;
        end
        else if (advance)
        begin
            for (int v = 0; v < VALVE_COUNT; v++)
            begin
                pulse_left_reg[v]  <= pulse_left_next[v];
                pwm_phase_reg[v]   <= pwm_phase_next[v];
                valve_mode_reg[v]  <= valve_mode_next[v];
                target_mode_reg[v] <= target_mode_next[v];
            end
            hold_enabled_reg <= hold_enabled_next;
            coil_on_reg      <= coil_on_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
